// ===== rtl/yuvrgb_pkg.sv =====
// shared types and constants for the yuv to rgb pixel packer
package yuvrgb_pkg;

  // input sample widths and the fixed-point layout
  localparam int unsigned SampleW  = 8;
  localparam int unsigned FracBits = 10;
  localparam int unsigned PixelW   = 24;
  localparam int unsigned OffsetW  = 10;  // signed width of an offset-removed sample
  localparam int unsigned CoefW    = 13;  // signed width of a conversion coefficient
  localparam int unsigned ProdW    = 22;  // signed width of a product
  localparam int unsigned SumW     = 22;  // signed width of a component sum

  // conversion coefficients, 10 fractional bits
  localparam logic signed [CoefW-1:0] LumaGain   = 13'sd1192;
  localparam logic signed [CoefW-1:0] RedFromV   = 13'sd1634;
  localparam logic signed [CoefW-1:0] GreenFromU = 13'sd400;
  localparam logic signed [CoefW-1:0] GreenFromV = 13'sd833;
  localparam logic signed [CoefW-1:0] BlueFromU  = 13'sd2066;

  // sample offsets
  localparam logic signed [OffsetW-1:0] LumaOffset   = 10'sd16;
  localparam logic signed [OffsetW-1:0] ChromaOffset = 10'sd128;

  // output packing codes
  typedef enum logic [1:0] {
    FMT_BGR24  = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_RGB332 = 2'd2
  } format_e;

  localparam format_e FormatReset = FMT_BGR24;

  // one input transaction
  typedef struct packed {
    logic [SampleW-1:0] luma;
    logic [SampleW-1:0] chroma_blue;
    logic [SampleW-1:0] chroma_red;
  } yuv_pixel_t;

  // one result transaction
  typedef struct packed {
    logic [PixelW-1:0]  packed_pixel;
    logic [SampleW-1:0] red_level;
    logic [SampleW-1:0] green_level;
    logic [SampleW-1:0] blue_level;
  } rgb_pixel_t;

endpackage

// ===== rtl/yuv_to_rgb_pixel_packer_top.sv =====
// yuv to rgb pixel packer: three-stage conversion pipeline with output register
//
// Input channel: in_valid_i / in_stall_o carry one yuv_pixel_t per transaction,
// a luma sample with the chroma pair that covers it (the feeder repeats chroma).
// Output channel: out_valid_o / out_stall_i carry one rgb_pixel_t per input
// transaction, in order: the clamped red, green and blue levels and the pixel
// packed per the format register.
// Configuration: cfg_we_i writes cfg_wdata_i into the 2-bit format register
// (0 = 24-bit with blue in the low byte, 1 = 5:5:5, 2 and 3 = 3:3:2). Write it
// only while no transaction is in flight.
// Pipeline: an accepted input passes through three register stages (products,
// sums, clamp and pack) before its result is valid.
// Throughput: one pixel per clock while the receiver does not stall; every stage then takes a new item each cycle.
// Reset clears all stage valid bits and sets the format to 24-bit.
// When the receiver stalls, the output register holds its result and the stages
// behind it fill up; in_stall_o rises only when every stage is occupied, so no
// transaction is lost or repeated and bubbles are squeezed out.
module yuv_to_rgb_pixel_packer_top
  import yuvrgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  yuv_pixel_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rgb_pixel_t out_data_o
);

  logic [1:0] format_q;

  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_en, s2_en, out_en;

  logic signed [OffsetW-1:0] c_off, d_off, e_off;
  logic signed [ProdW-1:0]   p_luma_d, p_rv_d, p_gu_d, p_gv_d, p_bu_d;
  logic signed [ProdW-1:0]   p_luma_q, p_rv_q, p_gu_q, p_gv_q, p_bu_q;
  logic signed [SumW-1:0]    sum_r_d, sum_g_d, sum_b_d;
  logic signed [SumW-1:0]    sum_r_q, sum_g_q, sum_b_q;
  logic [SampleW-1:0]        red_lvl, green_lvl, blue_lvl;
  logic [PixelW-1:0]         packed_d;
  rgb_pixel_t                out_data_q;

  // divide by 1024 toward zero and clamp to 0..255
  function automatic logic [SampleW-1:0] scale_clamp(input logic signed [SumW-1:0] sum);
    logic [SumW-FracBits-1:0] quot;
    quot = sum[SumW-1:FracBits];
    if (sum <= 0) begin
      scale_clamp = '0;
    end else if (quot > (SumW-FracBits)'(255)) begin
      scale_clamp = '1;
    end else begin
      scale_clamp = quot[SampleW-1:0];
    end
  endfunction

  // stage enables: a stage loads when it is empty or its successor moves on
  assign out_en     = !out_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FormatReset;
    end else if (cfg_we_i) begin
      format_q <= cfg_wdata_i;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_q  <= in_valid_i;
      if (s2_en)  s2_valid_q  <= s1_valid_q;
      if (out_en) out_valid_q <= s2_valid_q;
    end
  end

  // stage 1: remove offsets and form the five constant products
  always_comb begin
    c_off    = $signed({2'b00, in_data_i.luma}) - LumaOffset;
    d_off    = $signed({2'b00, in_data_i.chroma_blue}) - ChromaOffset;
    e_off    = $signed({2'b00, in_data_i.chroma_red}) - ChromaOffset;
    p_luma_d = ProdW'(c_off) * ProdW'(LumaGain);
    p_rv_d   = ProdW'(e_off) * ProdW'(RedFromV);
    p_gu_d   = ProdW'(d_off) * ProdW'(GreenFromU);
    p_gv_d   = ProdW'(e_off) * ProdW'(GreenFromV);
    p_bu_d   = ProdW'(d_off) * ProdW'(BlueFromU);
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      p_luma_q <= p_luma_d;
      p_rv_q   <= p_rv_d;
      p_gu_q   <= p_gu_d;
      p_gv_q   <= p_gv_d;
      p_bu_q   <= p_bu_d;
    end
  end

  // stage 2: component sums
  always_comb begin
    sum_r_d = SumW'(p_luma_q) + SumW'(p_rv_q);
    sum_g_d = SumW'(p_luma_q) - SumW'(p_gu_q) - SumW'(p_gv_q);
    sum_b_d = SumW'(p_luma_q) + SumW'(p_bu_q);
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
    end
  end

  // stage 3: scale, clamp and pack
  always_comb begin
    red_lvl   = scale_clamp(sum_r_q);
    green_lvl = scale_clamp(sum_g_q);
    blue_lvl  = scale_clamp(sum_b_q);
    unique case (format_q)
      FMT_BGR24:  packed_d = {red_lvl, green_lvl, blue_lvl};
      FMT_RGB555: packed_d = {9'd0, red_lvl[7:3], green_lvl[7:3], blue_lvl[7:3]};
      default:    packed_d = {16'd0, red_lvl[7:5], green_lvl[7:5], blue_lvl[7:6]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_data_q.packed_pixel <= packed_d;
      out_data_q.red_level    <= red_lvl;
      out_data_q.green_level  <= green_lvl;
      out_data_q.blue_level   <= blue_lvl;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
